[hdl/mcm_pkg.sv]
package mcm_pkg;

   localparam int OP_W        = 3;
   localparam int SYM_W       = 6;
   localparam int NODE_OUT_W  = 10;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_PAT_SYM  = 3'd1,
      OP_PAT_END  = 3'd2,
      OP_BUILD    = 3'd3,
      OP_TEXT_SYM = 3'd4,
      OP_RESTART  = 3'd5
   } opcode_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

[hdl/mcm_ram.sv]
module mcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hdl/multi_pattern_matcher.sv]
// channel  | dir | tdata (lsb first)                | tuser
// req_     | in  | symbol[5:0], pad                 | opcode[2:0]
// rsp_     | out | match, node[9:0], pad            | status
//
// one request at a time; a response register lets the next request in while
// the last response waits. goto and node memories have registered reads.
// pattern symbol: when a node is allocated, its goto row and node word are
// swept clean. text symbol: failure links are followed until a goto entry
// exists or the root is reached. build: the root row and each queued node are
// scanned breadth first, and each child gets its failure and suffix links.
// clear and reset sweep the root row; no request is taken meanwhile.
module multi_pattern_matcher #(
   parameter int MAX_NODES     = 1024,
   parameter int ALPHABET_SIZE = 62
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mcm_pkg::REQ_DATA_W-1:0]    req_tdata,   // symbol[5:0], pad
   input  logic [mcm_pkg::OP_W-1:0]          req_tuser,   // opcode[2:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mcm_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // match, node[9:0], pad
   output logic                              rsp_tuser    // status
);

   import mcm_pkg::*;

   localparam int NW     = $clog2(MAX_NODES);
   localparam int CNTW   = NW + 1;
   localparam int CW     = $clog2(ALPHABET_SIZE);
   localparam int GDEPTH = MAX_NODES * ALPHABET_SIZE;
   localparam int GAW    = $clog2(GDEPTH);
   localparam int NWORD  = 1 + 2 * NW;
   localparam logic [CNTW-1:0] NODE_LIMIT = CNTW'(MAX_NODES);
   localparam logic [CW-1:0]   LAST_SYM   = CW'(ALPHABET_SIZE - 1);

   typedef struct packed {
      logic          term;
      logic [NW-1:0] fail;
      logic [NW-1:0] tsl;
   } node_word_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_EXEC, S_INS_WT, S_TERM_WT, S_B_R0, S_B_GRD, S_B_GWT,
      S_B_FWT, S_ADV_RD, S_ADV_WT, S_B_FRD, S_B_FT, S_B_TT, S_B_NEXT, S_Q_WT,
      S_TXT_R1, S_TXT_W1, S_TXT_W2, S_DONE
   } state_type;

   function automatic logic [GAW-1:0] gaddr(input logic [NW-1:0] n, input logic [7:0] col);
      logic [31:0] a;
      a = 32'(n) * 32'(ALPHABET_SIZE) + 32'(col);
      return GAW'(a);
   endfunction

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [CNTW-1:0]   node_count_ff, node_count_in;
   logic [NW-1:0]     ins_ff, ins_in;
   logic [NW-1:0]     txt_ff, txt_in;
   logic              drop_ff, drop_in;
   logic [NW-1:0]     from_ff, from_in;
   logic [NW-1:0]     t_ff, t_in;
   logic [NW-1:0]     f_ff, f_in;
   logic [NW-1:0]     adv_n_ff, adv_n_in;
   logic              adv_build_ff, adv_build_in;
   logic [CNTW-1:0]   guard_ff, guard_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CNTW-1:0]   head_ff, head_in;
   logic [CNTW-1:0]   tail_ff, tail_in;
   logic [NW-1:0]     tsl_new_ff, tsl_new_in;
   logic              term_a_ff, term_a_in;
   logic [NW-1:0]     clr_node_ff, clr_node_in;
   logic              clr_silent_ff, clr_silent_in;
   logic              res_match_ff, res_match_in;
   logic [NW-1:0]     res_node_ff, res_node_in;
   logic              res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_match_ff, rsp_match_in;
   logic [NODE_OUT_W-1:0] rsp_node_ff, rsp_node_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              g_we;
   logic [GAW-1:0]    g_waddr, g_raddr;
   logic [NW-1:0]     g_wdata, g_rdata;
   logic              n_we;
   logic [NW-1:0]     n_waddr, n_raddr;
   logic [NWORD-1:0]  n_wdata, n_rdata;
   node_word_type     n_q, n_w;
   logic              q_we;
   logic [NW-1:0]     q_rdata;

   logic              sym_oob;
   logic [7:0]        adv_col;
   logic [NW+NODE_OUT_W-1:0] node_ext;

   assign sym_oob  = (32'(sym_ff) >= ALPHABET_SIZE);
   assign adv_col  = adv_build_ff ? 8'(col_ff) : 8'(sym_ff);
   assign n_q      = node_word_type'(n_rdata);
   assign n_wdata  = n_w;
   assign node_ext = {{NODE_OUT_W{1'b0}}, res_node_ff};

   // accesses to one entry are ordered by the sequencer; a read on the same edge as a write to it is never used
   always_comb begin
      g_raddr = gaddr(ins_ff, 8'(sym_ff));
      case (state_ff)
         S_B_GRD:  g_raddr = gaddr(from_ff, 8'(col_ff));
         S_ADV_RD: g_raddr = gaddr(adv_n_ff, adv_col);
         default:  g_raddr = gaddr(ins_ff, 8'(sym_ff));
      endcase
      g_we    = 1'b0;
      g_waddr = gaddr(clr_node_ff, 8'(col_ff));
      g_wdata = '0;
      if (state_ff == S_CLR) begin
         g_we = 1'b1;
      end else if (state_ff == S_INS_WT && g_rdata == '0 && node_count_ff < NODE_LIMIT) begin
         g_we    = 1'b1;
         g_waddr = gaddr(ins_ff, 8'(sym_ff));
         g_wdata = node_count_ff[NW-1:0];
      end

      case (state_ff)
         S_EXEC:   n_raddr = (op_ff == OP_BUILD) ? '0 : ins_ff;
         S_B_GWT:  n_raddr = from_ff;
         S_ADV_RD: n_raddr = adv_n_ff;
         S_B_FRD:  n_raddr = f_ff;
         S_B_FT:   n_raddr = t_ff;
         S_TXT_R1: n_raddr = txt_ff;
         S_TXT_W1: n_raddr = n_q.tsl;
         default:  n_raddr = '0;
      endcase
      n_we    = 1'b0;
      n_waddr = clr_node_ff;
      n_w     = '0;
      case (state_ff)
         S_CLR: begin
            n_we = (col_ff == '0);
         end
         S_TERM_WT: begin
            n_we    = 1'b1;
            n_waddr = ins_ff;
            n_w     = '{term: 1'b1, fail: n_q.fail, tsl: n_q.tsl};
         end
         S_B_R0: begin
            n_we    = 1'b1;
            n_waddr = '0;
            n_w     = '{term: n_q.term, fail: '0, tsl: '0};
         end
         S_B_TT: begin
            n_we    = 1'b1;
            n_waddr = t_ff;
            n_w     = '{term: n_q.term, fail: f_ff, tsl: tsl_new_ff};
         end
         default: ;
      endcase

      q_we = (state_ff == S_B_GWT) && (g_rdata != '0) && (tail_ff < NODE_LIMIT);
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sym_in        = sym_ff;
      node_count_in = node_count_ff;
      ins_in        = ins_ff;
      txt_in        = txt_ff;
      drop_in       = drop_ff;
      from_in       = from_ff;
      t_in          = t_ff;
      f_in          = f_ff;
      adv_n_in      = adv_n_ff;
      adv_build_in  = adv_build_ff;
      guard_in      = guard_ff;
      col_in        = col_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      tsl_new_in    = tsl_new_ff;
      term_a_in     = term_a_ff;
      clr_node_in   = clr_node_ff;
      clr_silent_in = clr_silent_ff;
      res_match_in  = res_match_ff;
      res_node_in   = res_node_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLR: begin
            col_in = col_ff + 1'b1;
            if (col_ff == LAST_SYM) begin
               col_in   = '0;
               state_in = clr_silent_ff ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               sym_in   = req_tdata[SYM_W-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_match_in  = 1'b0;
            res_node_in   = '0;
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
            case (op_ff)
               OP_CLEAR: begin
                  node_count_in = CNTW'(1);
                  ins_in        = '0;
                  txt_in        = '0;
                  drop_in       = 1'b0;
                  clr_node_in   = '0;
                  col_in        = '0;
                  clr_silent_in = 1'b0;
                  state_in      = S_CLR;
               end
               OP_PAT_SYM: begin
                  res_node_in = ins_ff;
                  if (drop_ff) begin
                     res_status_in = STATUS_FULL;
                  end else if (!sym_oob) begin
                     state_in = S_INS_WT;
                  end
               end
               OP_PAT_END: begin
                  res_node_in = ins_ff;
                  if (drop_ff) begin
                     res_status_in = STATUS_FULL;
                     drop_in       = 1'b0;
                     ins_in        = '0;
                  end else begin
                     state_in = S_TERM_WT;
                  end
               end
               OP_BUILD: begin
                  txt_in   = '0;
                  state_in = S_B_R0;
               end
               OP_TEXT_SYM: begin
                  if (sym_oob) begin
                     txt_in   = '0;
                     state_in = S_TXT_R1;
                  end else begin
                     adv_n_in     = txt_ff;
                     adv_build_in = 1'b0;
                     guard_in     = '0;
                     state_in     = S_ADV_RD;
                  end
               end
               OP_RESTART: begin
                  txt_in = '0;
               end
               default: begin
                  res_node_in = txt_ff;
               end
            endcase
         end
         S_INS_WT: begin
            state_in = S_DONE;
            if (g_rdata != '0) begin
               ins_in      = g_rdata;
               res_node_in = g_rdata;
            end else if (node_count_ff >= NODE_LIMIT) begin
               drop_in       = 1'b1;
               res_status_in = STATUS_FULL;
            end else begin
               // fresh node: sweep its goto row and node word
               ins_in        = node_count_ff[NW-1:0];
               res_node_in   = node_count_ff[NW-1:0];
               clr_node_in   = node_count_ff[NW-1:0];
               node_count_in = node_count_ff + 1'b1;
               col_in        = '0;
               clr_silent_in = 1'b0;
               state_in      = S_CLR;
            end
         end
         S_TERM_WT: begin
            ins_in   = '0;
            state_in = S_DONE;
         end
         S_B_R0: begin
            from_in  = '0;
            col_in   = '0;
            head_in  = '0;
            tail_in  = '0;
            state_in = S_B_GRD;
         end
         S_B_GRD: begin
            state_in = S_B_GWT;
         end
         S_B_GWT: begin
            if (q_we) begin
               t_in     = g_rdata;
               tail_in  = tail_ff + 1'b1;
               state_in = S_B_FWT;
            end else begin
               state_in = S_B_NEXT;
            end
         end
         S_B_FWT: begin
            adv_n_in     = n_q.fail;
            adv_build_in = 1'b1;
            guard_in     = '0;
            state_in     = S_ADV_RD;
         end
         S_ADV_RD: begin
            state_in = S_ADV_WT;
         end
         S_ADV_WT: begin
            if (g_rdata != '0 || adv_n_ff == '0) begin
               if (adv_build_ff) begin
                  f_in     = (g_rdata == t_ff) ? '0 : g_rdata;
                  state_in = S_B_FRD;
               end else begin
                  txt_in   = g_rdata;
                  state_in = S_TXT_R1;
               end
            end else if (guard_ff >= NODE_LIMIT) begin
               adv_n_in = '0;
               state_in = S_ADV_RD;
            end else begin
               adv_n_in = n_q.fail;
               guard_in = guard_ff + 1'b1;
               state_in = S_ADV_RD;
            end
         end
         S_B_FRD: begin
            state_in = S_B_FT;
         end
         S_B_FT: begin
            tsl_new_in = n_q.term ? f_ff : n_q.tsl;
            state_in   = S_B_TT;
         end
         S_B_TT: begin
            state_in = S_B_NEXT;
         end
         S_B_NEXT: begin
            if (col_ff == LAST_SYM) begin
               if (head_ff < tail_ff) begin
                  head_in  = head_ff + 1'b1;
                  state_in = S_Q_WT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = S_B_GRD;
            end
         end
         S_Q_WT: begin
            from_in  = q_rdata;
            col_in   = '0;
            state_in = S_B_GRD;
         end
         S_TXT_R1: begin
            res_node_in = txt_ff;
            state_in    = S_TXT_W1;
         end
         S_TXT_W1: begin
            term_a_in = n_q.term;
            state_in  = S_TXT_W2;
         end
         S_TXT_W2: begin
            res_match_in = term_a_ff | n_q.term;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_match_in  = res_match_ff;
               rsp_node_in   = node_ext[NODE_OUT_W-1:0];
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         node_count_ff <= CNTW'(1);
         ins_ff        <= '0;
         txt_ff        <= '0;
         drop_ff       <= 1'b0;
         col_ff        <= '0;
         clr_node_ff   <= '0;
         clr_silent_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         ins_ff        <= ins_in;
         txt_ff        <= txt_in;
         drop_ff       <= drop_in;
         col_ff        <= col_in;
         clr_node_ff   <= clr_node_in;
         clr_silent_ff <= clr_silent_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_ff         <= op_in;
         sym_ff        <= sym_in;
         from_ff       <= from_in;
         t_ff          <= t_in;
         f_ff          <= f_in;
         adv_n_ff      <= adv_n_in;
         adv_build_ff  <= adv_build_in;
         guard_ff      <= guard_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         tsl_new_ff    <= tsl_new_in;
         term_a_ff     <= term_a_in;
         res_match_ff  <= res_match_in;
         res_node_ff   <= res_node_in;
         res_status_ff <= res_status_in;
         rsp_match_ff  <= rsp_match_in;
         rsp_node_ff   <= rsp_node_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   mcm_ram #(.WIDTH(NW), .DEPTH(GDEPTH)) u_goto_ram (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   mcm_ram #(.WIDTH(NWORD), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   mcm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff[NW-1:0]),
      .wr_data (g_rdata),
      .rd_addr (head_ff[NW-1:0]),
      .rd_data (q_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - NODE_OUT_W - 1){1'b0}}, rsp_node_ff, rsp_match_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      node_count_ff >= CNTW'(1) && node_count_ff <= NODE_LIMIT)
      else $error("node count out of range");
   a_ins_alloc : assert property (@(posedge clock) disable iff (reset)
      CNTW'(ins_ff) < node_count_ff)
      else $error("insert cursor beyond allocated nodes");
   a_txt_alloc : assert property (@(posedge clock) disable iff (reset)
      CNTW'(txt_ff) < node_count_ff)
      else $error("text cursor beyond allocated nodes");
   a_queue_order : assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff || state_ff == S_IDLE || state_ff == S_EXEC)
      else $error("build queue head passed tail");
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_EXEC)
      else $error("accepted request not decoded");
`endif

endmodule

[dv/tb_multi_pattern_matcher.sv]
module tb_multi_pattern_matcher;
   import mcm_pkg::*;

   localparam int NODES    = 1024;
   localparam int ALPHA    = 62;
   localparam int WD_LIMIT = 1000000;

   // opcodes with no function
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic       match;
      logic [9:0] node;
      logic       status;
   } rsp_fields_type;

   class match_scoreboard;
      logic [9:0]  goto_tbl [NODES*ALPHA];
      logic        term     [NODES];
      logic [9:0]  fail     [NODES];
      logic [9:0]  tsuf     [NODES];
      logic [9:0]  bfs_q    [NODES];
      int          node_cnt;
      int          ins_cur;
      int          txt_cur;
      bit          dropping;
      rsp_fields_type pending_rsp[$];
      int          errors;

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         foreach (goto_tbl[i]) goto_tbl[i] = '0;
         foreach (term[i]) begin
            term[i] = 1'b0;
            fail[i] = '0;
            tsuf[i] = '0;
         end
         node_cnt = 1;
         ins_cur  = 0;
         txt_cur  = 0;
         dropping = 1'b0;
      endfunction

      function int child(int n, int c);
         if (n >= NODES || c >= ALPHA) return 0;
         return goto_tbl[n*ALPHA + c];
      endfunction

      // fall back along failure links until a c-child exists or root
      function int step_text(int n, int c);
         int hops;
         hops = 0;
         while (n > 0 && child(n, c) == 0 && hops < NODES) begin
            n = fail[n];
            hops++;
         end
         if (child(n, c) == 0 && n > 0) n = 0;
         return child(n, c);
      endfunction

      function void link_all();
         int head, tail, from, t, f;
         head = 0;
         tail = 0;
         fail[0] = '0;
         tsuf[0] = '0;
         for (int c = 0; c < ALPHA; c++) begin
            t = child(0, c);
            if (t > 0 && tail < NODES) begin
               fail[t] = '0;
               tsuf[t] = '0;
               bfs_q[tail++] = 10'(t);
            end
         end
         while (head < tail) begin
            from = bfs_q[head++];
            for (int c = 0; c < ALPHA; c++) begin
               t = child(from, c);
               if (t == 0 || tail >= NODES) continue;
               bfs_q[tail++] = 10'(t);
               f = step_text(fail[from], c);
               if (f == t) f = 0;
               fail[t] = 10'(f);
               tsuf[t] = term[f] ? f[9:0] : tsuf[f];
            end
         end
      endfunction

      function void note_request(logic [2:0] op, logic [5:0] sym);
         rsp_fields_type r;
         int idx;
         r = '0;
         case (op)
            OP_CLEAR: wipe();
            OP_PAT_SYM: begin
               if (dropping) r.status = STATUS_FULL;
               else if (sym < ALPHA) begin
                  idx = ins_cur*ALPHA + sym;
                  if (goto_tbl[idx] == 0) begin
                     if (node_cnt >= NODES) begin
                        dropping = 1'b1;
                        r.status = STATUS_FULL;
                     end else begin
                        goto_tbl[idx] = 10'(node_cnt);
                        node_cnt++;
                     end
                  end
                  if (!dropping) ins_cur = goto_tbl[idx];
               end
               r.node = 10'(ins_cur);
            end
            OP_PAT_END: begin
               r.node = 10'(ins_cur);
               if (dropping) r.status = STATUS_FULL;
               else term[ins_cur] = 1'b1;
               dropping = 1'b0;
               ins_cur  = 0;
            end
            OP_BUILD: begin
               link_all();
               txt_cur = 0;
            end
            OP_TEXT_SYM: begin
               txt_cur = step_text(txt_cur, sym);
               r.node  = 10'(txt_cur);
               r.match = term[txt_cur] | term[tsuf[txt_cur]];
            end
            OP_RESTART: txt_cur = 0;
            default: r.node = 10'(txt_cur);
         endcase
         pending_rsp.insert(pending_rsp.size(), r);
      endfunction

      function void check_response(logic [15:0] data, logic user);
         rsp_fields_type e;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: data %h status %0d", data, user);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (data[0] !== e.match) begin
            $error("match: expected %0d actual %0d", e.match, data[0]);
            errors++;
         end
         if (data[10:1] !== e.node) begin
            $error("node: expected %0d actual %0d", e.node, data[10:1]);
            errors++;
         end
         if (user !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, user);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   match_scoreboard sb;
   bit  quiet;
   bit  pressure_req;
   bit  filled;
   int  sent;
   int  idle_cycles;

   multi_pattern_matcher dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver side, with a long hold-off on request
   initial begin : sink
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_req && hold == 0) begin
            pressure_req = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else begin
            rsp_tready = quiet || ($urandom_range(99) >= 10);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata[5:0]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send(logic [2:0] op, logic [5:0] sym);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 10) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {2'b00, sym};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   function automatic logic [5:0] pick_sym();
      if ($urandom_range(99) < 12) return 6'($urandom_range(63));
      return 6'($urandom_range(3));
   endfunction

   // one long chain pattern runs the node table out
   task automatic fill_table();
      send(OP_CLEAR, 0);
      repeat (NODES + 4) send(OP_PAT_SYM, 6'($urandom_range(ALPHA-1)));
      send(OP_PAT_END, 0);
      send(OP_PAT_SYM, 6'($urandom_range(ALPHA-1)));
      send(OP_PAT_END, 0);
      send(OP_BUILD, 0);
      repeat (30) send(OP_TEXT_SYM, 6'($urandom_range(63)));
      send(OP_CLEAR, 0);
   endtask

   initial begin
      sb = new();
      quiet = 1'b0;
      pressure_req = 1'b0;
      filled = 1'b0;
      sent = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send(OP_PAT_SYM, 0);
      send(OP_TEXT_SYM, 0);
      send(OP_PAT_SYM, 61);
      send(OP_PAT_SYM, 62);
      send(OP_PAT_SYM, 63);
      send(OP_PAT_END, 0);
      send(OP_PAT_SYM, 61);
      send(OP_PAT_END, 0);
      send(OP_BUILD, 0);
      send(OP_TEXT_SYM, 0);
      send(OP_TEXT_SYM, 61);
      send(OP_TEXT_SYM, 61);
      send(OP_TEXT_SYM, 63);
      send(OP_TEXT_SYM, 62);
      send(OP_SPARE_A, 6'h3f);
      send(OP_SPARE_B, 0);
      send(OP_RESTART, 0);
      send(OP_PAT_END, 0);       // empty pattern marks the root
      send(OP_BUILD, 0);
      send(OP_TEXT_SYM, 5);
      send(OP_TEXT_SYM, 63);
      send(OP_CLEAR, 0);
      send(OP_TEXT_SYM, 0);

      pressure_req = 1'b1;
      while (sent < 1950) begin
         quiet = (sent > 700 && sent < 1000);
         if (!filled && sent > 800) begin
            fill_table();
            filled = 1'b1;
         end
         if ($urandom_range(99) < 10) send(OP_CLEAR, 0);
         repeat ($urandom_range(5, 1)) begin
            repeat ($urandom_range(6, 1)) send(OP_PAT_SYM, pick_sym());
            send(OP_PAT_END, 0);
         end
         if ($urandom_range(99) < 90) send(OP_BUILD, 0);
         repeat ($urandom_range(40, 10)) begin
            case ($urandom_range(99)) inside
               [0:2]: send(OP_RESTART, 0);
               [3:5]: send(3'($urandom_range(7)), 6'($urandom_range(63)));
               default: send(OP_TEXT_SYM, pick_sym());
            endcase
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", sb.pending_rsp.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
